[src/ptt_pkg.sv]
`timescale 1ns / 1ps

package ptt_pkg;

	// Operation codes carried in the func field of a request.
	localparam logic FUNC_ADD = 1'b0;
	localparam logic FUNC_RUN = 1'b1;

	// Result kinds.
	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_RUN = 1'b1;

	// A run pass reports at most this many fired slots.
	localparam int unsigned MAX_RESULTS = 8;

	typedef struct packed {
		logic        func;
		logic [31:0] now;
		logic [31:0] period;
		logic        one_shot;
		logic        start_enabled;
		logic        handler_present;
	} req_t;

	typedef struct packed {
		logic       kind;
		logic       accepted;
		logic [2:0] slot;
		logic       fired;
		logic       last;
	} rsp_t;

	// Request after classification in the front part.
	typedef struct packed {
		logic        func;
		logic [31:0] now;
		logic [31:0] period;
		logic        one_shot;
		logic        start_enabled;
		logic        add_ok;
	} work_t;

endpackage

[src/ptt_front.sv]
`timescale 1ns / 1ps

module ptt_front import ptt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  q_valid,
	input  logic  q_pop,
	output work_t q_item
);

	localparam int unsigned DEPTH = 2;

	work_t      mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	work_t      item_in;

	assign req_ready = (cnt_q != 2'(DEPTH));
	assign push      = req_valid && req_ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = mem_q[rd_ptr_q];

	// An add is known to fail here when it has no handler or a zero interval.
	always_comb begin
		item_in.func          = req.func;
		item_in.now           = req.now;
		item_in.period        = req.period;
		item_in.one_shot      = req.one_shot;
		item_in.start_enabled = req.start_enabled;
		item_in.add_ok        = req.handler_present && (req.period != 32'd0);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

[src/ptt_back.sv]
`timescale 1ns / 1ps

module ptt_back import ptt_pkg::*; #(
	parameter int unsigned SLOT_COUNT = 8
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  q_valid,
	output logic  q_pop,
	input  work_t q_item,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);

	localparam int unsigned IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned CW = $clog2(SLOT_COUNT + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t        state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [3:0]    n_q;
	logic          pend_q;
	logic [2:0]    pend_slot_q;
	logic [31:0]   now_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic [31:0]   per_q  [SLOT_COUNT];
	logic [31:0]   last_q [SLOT_COUNT];
	logic          en_q   [SLOT_COUNT];
	logic          os_q   [SLOT_COUNT];

	logic          out_free;
	logic          is_add;
	logic          add_acc;
	logic          add_go;
	logic          run_start;
	logic [IW-1:0] cur;
	logic [IW-1:0] wr_slot;
	logic [31:0]   elapsed;
	logic          at_end;
	logic          fire;
	logic          report;
	logic          need_emit;
	logic          step_go;
	logic          finish_go;

	assign out_free  = !out_valid_q || rsp_ready;
	assign is_add    = (q_item.func == FUNC_ADD);
	assign add_acc   = q_item.add_ok && (count_q < CW'(SLOT_COUNT));
	assign add_go    = (state_q == ST_IDLE) && q_valid && is_add && out_free;
	assign run_start = (state_q == ST_IDLE) && q_valid && !is_add;
	assign q_pop     = add_go || run_start;
	assign wr_slot   = count_q[IW-1:0];

	assign cur       = idx_q[IW-1:0];
	assign at_end    = (idx_q == count_q);
	assign elapsed   = now_q - last_q[cur];
	assign fire      = !at_end && en_q[cur] && (elapsed >= per_q[cur]);
	assign report    = (n_q < 4'(MAX_RESULTS));
	assign need_emit = fire && report && pend_q;
	assign step_go   = (state_q == ST_RUN) && !at_end && (!need_emit || out_free);
	assign finish_go = (state_q == ST_RUN) && at_end && out_free;

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Slot storage: payload only, no reset.
	always_ff @(posedge clk) begin
		if (add_go && add_acc) begin
			per_q[wr_slot]  <= q_item.period;
			last_q[wr_slot] <= q_item.now;
			en_q[wr_slot]   <= q_item.start_enabled;
			os_q[wr_slot]   <= q_item.one_shot;
		end
		if (step_go && fire) begin
			if (os_q[cur]) begin
				en_q[cur] <= 1'b0;
			end else begin
				last_q[cur] <= now_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			n_q         <= 4'd0;
			pend_q      <= 1'b0;
			pend_slot_q <= 3'd0;
			now_q       <= 32'd0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (add_go) begin
						out_valid_q    <= 1'b1;
						out_q.kind     <= KIND_ADD;
						out_q.accepted <= add_acc;
						out_q.slot     <= add_acc ? 3'(wr_slot) : 3'd0;
						out_q.fired    <= 1'b0;
						out_q.last     <= 1'b1;
						if (add_acc) begin
							count_q <= count_q + CW'(1);
						end
					end else if (run_start) begin
						now_q   <= q_item.now;
						idx_q   <= '0;
						n_q     <= 4'd0;
						pend_q  <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_go) begin
						idx_q <= idx_q + CW'(1);
						if (fire && report) begin
							n_q         <= n_q + 4'd1;
							pend_q      <= 1'b1;
							pend_slot_q <= 3'(cur);
							// The held report is now known not to be the final one.
							if (pend_q) begin
								out_valid_q    <= 1'b1;
								out_q.kind     <= KIND_RUN;
								out_q.accepted <= 1'b0;
								out_q.slot     <= pend_slot_q;
								out_q.fired    <= 1'b1;
								out_q.last     <= 1'b0;
							end
						end
					end else if (finish_go) begin
						out_valid_q    <= 1'b1;
						out_q.kind     <= KIND_RUN;
						out_q.accepted <= 1'b0;
						out_q.slot     <= pend_q ? pend_slot_q : 3'd0;
						out_q.fired    <= pend_q;
						out_q.last     <= 1'b1;
						pend_q         <= 1'b0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOT_COUNT))
		else $error("task count exceeds slot count");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (idx_q <= count_q))
		else $error("run walk index passed task count");

	a_add_count: assert property (@(posedge clk) disable iff (!arst_n)
		(add_go && add_acc) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("stored task did not advance task count");

	a_no_pop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !q_pop)
		else $error("queue popped during run pass");
`endif

endmodule

[src/periodic_task_timer_table.sv]
`timescale 1ns / 1ps

// Periodic task timer table.
// Requests arrive on the req channel (req_valid / req_ready, payload req) and
// results leave on the rsp channel (rsp_valid / rsp_ready, payload rsp). A
// transaction is completed at a rising edge where valid and ready are high.
// An add request yields one acknowledgement; a run request yields one report
// per fired slot up to MAX_RESULTS, the final one flagged by last, or a single
// empty report. A two-entry request queue sits in front of the slot sequencer,
// so requests are taken while the sequencer works and while a result waits at
// the output. An add result is registered in the output register once the
// sequencer takes the add from the queue. A run pass has a setup step, a walk
// over the occupied slots and a close step that emits the final report; the
// walk compares one slot per cycle while the output can take its reports.
// When the receiver stalls, the single output register holds its result; the
// walk pauses only when another report must be emitted, and the queue fills
// before req_ready drops.
// Reset clears the task count, the queue and the output register; slot
// contents are not cleared, since only counted slots are ever read.

module periodic_task_timer_table import ptt_pkg::*; #(
	parameter int unsigned SLOT_COUNT = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	// Queue handshake between the front and the back part.
	logic  q_valid;
	logic  q_pop;
	work_t q_item;

	// The front part classifies add requests and buffers all requests.
	ptt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item)
	);

	// The back part owns the slot table and walks it for run passes.
	ptt_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_item    (q_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

// Testbench for the periodic task timer table.
//
// Requests go in through the req channel and results come back on the rsp
// channel. Every accepted request is run through a predictor that keeps its
// own copy of the task table: interval, last-run tick, enable bit and one-shot
// bit per slot, plus the count of stored tasks. The predictor queues the
// results that the request should cause. A separate checker pops the oldest
// expected result for every rsp transaction and compares it field by field.
//
// The run holds these tests, in order:
//   - adds that must be rejected, and a run pass on the empty table,
//   - filling all eight slots with a mix of intervals, one-shot and periodic
//     tasks and one task that starts disabled, then an add on a full table,
//   - directed run passes: nothing due, almost every slot due at once, tick
//     wrap-around and the extreme intervals,
//   - random traffic under three idling patterns,
//   - a long receiver hold-off while the sender keeps offering requests.
//
// The block is reset once. Since tasks are never removed, the table stays full
// after the fill test, and every later add is rejected.

module tb;
	import ptt_pkg::*;

	localparam int unsigned SLOTS           = 8;
	localparam int unsigned RSP_HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// Predictor copy of the task table.
	logic [31:0] slot_period   [SLOTS];
	logic [31:0] slot_last_run [SLOTS];
	logic        slot_enabled  [SLOTS];
	logic        slot_one_shot [SLOTS];
	int unsigned tasks_stored = 0;

	// Results the block still owes, oldest first.
	rsp_t expected_rsp_q[$];

	int          failures          = 0;
	int          sender_idle_pct   = 0;
	int          receiver_idle_pct = 0;
	// The test asks for a receiver hold-off by bumping hold_requests; the
	// receiver process counts the hold-offs it has carried out.
	int          hold_requests     = 0;
	int          holds_served      = 0;
	// Tick that the random traffic walks forward from.
	logic [31:0] walk_tick         = 32'd2000;

	periodic_task_timer_table #(
		.SLOT_COUNT(SLOTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Work out the results that one accepted request causes, and update the
	// predicted table the same way the block should.
	function automatic void predict_results(input req_t item);
		rsp_t        report;
		rsp_t        held_report;
		logic        have_held;
		int unsigned reported;
		logic [31:0] elapsed;
		report    = '0;
		have_held = 1'b0;
		reported  = 0;
		if (item.func == FUNC_ADD) begin
			report.kind = KIND_ADD;
			report.last = 1'b1;
			if (item.handler_present && item.period != 32'd0 && tasks_stored < SLOTS) begin
				slot_period[tasks_stored]   = item.period;
				slot_last_run[tasks_stored] = item.now;
				slot_enabled[tasks_stored]  = item.start_enabled;
				slot_one_shot[tasks_stored] = item.one_shot;
				report.accepted = 1'b1;
				report.slot     = tasks_stored[2:0];
				tasks_stored++;
			end
			expected_rsp_q.push_back(report);
		end else begin
			// Only stored slots are looked at. The subtraction wraps modulo
			// 2^32, so a tick that rolled over still gives the right age.
			for (int i = 0; i < tasks_stored; i++) begin
				elapsed = item.now - slot_last_run[i];
				if (slot_enabled[i] && elapsed >= slot_period[i]) begin
					if (slot_one_shot[i])
						slot_enabled[i] = 1'b0;
					else
						slot_last_run[i] = item.now;
					if (reported < MAX_RESULTS) begin
						// Hold each report back one step so that the final
						// one can be flagged with last.
						if (have_held)
							expected_rsp_q.push_back(held_report);
						held_report       = '0;
						held_report.kind  = KIND_RUN;
						held_report.slot  = i[2:0];
						held_report.fired = 1'b1;
						have_held         = 1'b1;
						reported++;
					end
				end
			end
			if (have_held) begin
				held_report.last = 1'b1;
				expected_rsp_q.push_back(held_report);
			end else begin
				// Nothing was due: a single empty pass report.
				report.kind = KIND_RUN;
				report.last = 1'b1;
				expected_rsp_q.push_back(report);
			end
		end
	endfunction

	function automatic void check_field(input string field_name, input logic [2:0] want,
			input logic [2:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
			failures++;
		end
	endfunction

	// Offer one request and hold it until the block takes it. The sender may
	// idle first; valid is only lowered in a step where it is not raised.
	task automatic send_request(input req_t item);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_results(item);
	endtask

	task automatic send_add(input logic [31:0] tick, input logic [31:0] interval,
			input logic once, input logic enabled, input logic handler);
		req_t item;
		item.func            = FUNC_ADD;
		item.now             = tick;
		item.period          = interval;
		item.one_shot        = once;
		item.start_enabled   = enabled;
		item.handler_present = handler;
		send_request(item);
	endtask

	// A run pass looks at the tick alone, so the other fields carry noise.
	task automatic send_run(input logic [31:0] tick);
		req_t item;
		item.func            = FUNC_RUN;
		item.now             = tick;
		item.period          = $urandom;
		item.one_shot        = 1'($urandom_range(0, 1));
		item.start_enabled   = 1'($urandom_range(0, 1));
		item.handler_present = 1'($urandom_range(0, 1));
		send_request(item);
	endtask

	// Stop offering, wait for every owed result, then keep watching the block so
	// that any stray result would show up.
	task automatic wait_results_drained();
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 4)
			@(posedge clk);
	endtask

	// Rejected adds: zero interval, no handler, and both at once. A run pass
	// on the empty table must still give its single empty report.
	task automatic test_add_rejections();
		send_add(32'd1000, 32'd0, 1'b0, 1'b1, 1'b1);
		send_add(32'd1000, 32'd5, 1'b0, 1'b1, 1'b0);
		send_add(32'd1000, 32'd0, 1'b1, 1'b0, 1'b0);
		send_run(32'd1000);
	endtask

	// Fill every slot, all stamped at tick 1000, then try one more add.
	task automatic test_fill_table();
		send_add(32'd1000, 32'd1,          1'b0, 1'b1, 1'b1);
		send_add(32'd1000, 32'hFFFF_FFFF,  1'b0, 1'b1, 1'b1);
		send_add(32'd1000, 32'd100,        1'b1, 1'b1, 1'b1);
		send_add(32'd1000, 32'd1000,       1'b0, 1'b1, 1'b1);
		send_add(32'd1000, 32'd1,          1'b1, 1'b1, 1'b1);
		// This task never runs, because it starts disabled.
		send_add(32'd1000, 32'd1,          1'b0, 1'b0, 1'b1);
		send_add(32'd1000, 32'd50,         1'b0, 1'b1, 1'b1);
		send_add(32'd1000, 32'h8000_0000,  1'b0, 1'b1, 1'b1);
		// The table is full now, so a valid add is turned away.
		send_add(32'd1000, 32'd7,          1'b0, 1'b1, 1'b1);
	endtask

	task automatic test_run_passes();
		// Same tick as the adds: nothing is due yet.
		send_run(32'd1000);
		// One tick behind the adds is the longest possible age, so every
		// enabled slot fires, including the one with the largest interval.
		send_run(32'd999);
		// One-shot slots are now off; only the periodic slot with interval 1 fires.
		send_run(32'd1001);
		// Tick values at the edges of the counter, wrapping through zero.
		send_run(32'hFFFF_FFFF);
		send_run(32'h0000_0000);
		send_run(32'h8000_0000);
		// Repeating a tick leaves nothing due for the periodic slots.
		send_run(32'h8000_0000);
	endtask

	// Random traffic: mostly run passes with a tick that moves forward by
	// small steps, now and then a large jump, a random tick or a step back.
	// About a quarter are adds with random fields; all of them are rejected.
	task automatic test_random_traffic(input int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 25) begin
				send_add($urandom, ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70)
					walk_tick = walk_tick + $urandom_range(0, 120);
				else if (pick < 85)
					walk_tick = walk_tick + $urandom_range(0, 5000);
				else if (pick < 95)
					walk_tick = $urandom;
				else
					walk_tick = walk_tick - $urandom_range(1, 10);
				send_run(walk_tick);
			end
		end
	endtask

	// The receiver stops taking results for a long stretch while the sender
	// keeps offering run passes, so the request queue fills and req_ready
	// has to drop until the receiver picks up again.
	task automatic test_backpressure();
		hold_requests <= hold_requests + 1;
		for (int n = 0; n < 16; n++) begin
			walk_tick = walk_tick + $urandom_range(1, 60);
			send_run(walk_tick);
		end
		wait_results_drained();
	endtask

	// Receiver: takes results with random stalls, and carries out any
	// requested hold-off, counting its cycles here.
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				rsp_ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES)
					@(posedge clk);
				holds_served++;
			end
			rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Checker: every result transaction is matched against the oldest
	// expected result.
	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_rsp_q.size() == 0) begin
				$error("result transaction with none expected: kind %0d slot %0d",
					rsp.kind, rsp.slot);
				failures++;
			end else begin
				want = expected_rsp_q.pop_front();
				check_field("kind",     want.kind,     rsp.kind);
				check_field("accepted", want.accepted, rsp.accepted);
				check_field("slot",     want.slot,     rsp.slot);
				check_field("fired",    want.fired,    rsp.fired);
				check_field("last",     want.last,     rsp.last);
			end
		end
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender rarely idles, receiver stalls most of the time.
		sender_idle_pct   = 7;
		receiver_idle_pct = 83;
		test_add_rejections();
		test_fill_table();
		test_run_passes();
		test_random_traffic(155);

		// The other way round.
		sender_idle_pct   = 83;
		receiver_idle_pct = 7;
		test_random_traffic(155);

		// Neither side idles.
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		test_random_traffic(155);
		test_backpressure();

		wait_results_drained();
		if (expected_rsp_q.size() != 0)
			$error("%0d expected results never arrived", expected_rsp_q.size());
		if (failures == 0 && expected_rsp_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#(5_000_000);
		$error("timeout with %0d results still expected", expected_rsp_q.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

[periodic_task_timer_table.f]
src/ptt_pkg.sv
src/ptt_front.sv
src/ptt_back.sv
src/periodic_task_timer_table.sv
verif/tb.sv
